/* rtl/clks_pkg.sv */
// ----------------------------------------------------------------------------
// clks_pkg
// Types, constants and the pattern table for the control line stripper.
// ----------------------------------------------------------------------------
package clks_pkg;

    localparam int unsigned PAT_LEN = 6;
    localparam int unsigned CNT_W   = 3;

    localparam logic [7:0] CR_BYTE = 8'h0D;

    // One input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
        logic       run_last;
    } t_out_word;

    // Compact description of the results caused by one input word:
    // held_n pattern bytes, then the input byte if has_byte, and an empty
    // end marker when nothing else goes out at end of message.
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] held_n;
        logic             has_byte;
        logic             eom;
        logic [7:0]       data;
    } t_run;

    // 0x01 'I' 'N' 'T' 'L' ' '
    function automatic logic [7:0] pat_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h49;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h54;
            3'd4:    b = 8'h4C;
            3'd5:    b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/clks_step.sv */
// ----------------------------------------------------------------------------
// clks_step
// Line state tracking. Turns each accepted input word into a run
// descriptor and holds it in a one-entry pending register.
// ----------------------------------------------------------------------------
module clks_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  clks_pkg::t_in_word i_data,
    input  logic              i_take,
    output clks_pkg::t_run    o_run
);

    logic                         r_ls;
    logic                         r_drop;
    logic [clks_pkg::CNT_W-1:0]   r_held;
    clks_pkg::t_run               r_pend;

    logic                         n_ls;
    logic                         n_drop;
    logic [clks_pkg::CNT_W-1:0]   n_held;
    clks_pkg::t_run               n_run;

    logic accept;
    logic is_cr;
    logic match;

    assign o_stall = r_pend.vld && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_run   = r_pend;

    assign is_cr = (i_data.data_byte == clks_pkg::CR_BYTE);
    assign match = (i_data.data_byte == clks_pkg::pat_byte(r_held));

    always_comb begin
        n_ls           = r_ls;
        n_drop         = r_drop;
        n_held         = r_held;
        n_run.vld      = 1'b0;
        n_run.held_n   = '0;
        n_run.has_byte = 1'b0;
        n_run.eom      = i_data.end_of_message;
        n_run.data     = i_data.data_byte;

        if (r_drop) begin
            if (is_cr) begin
                n_run.has_byte = 1'b1;
                n_drop         = 1'b0;
                n_ls           = 1'b1;
            end
        end else if (r_ls) begin
            if (match) begin
                if (r_held == clks_pkg::CNT_W'(clks_pkg::PAT_LEN - 1)) begin
                    // pattern complete: drop the line
                    n_held = '0;
                    n_drop = 1'b1;
                    n_ls   = 1'b0;
                end else begin
                    n_held = r_held + 1'b1;
                end
            end else begin
                // flush the held prefix, then pass the byte
                n_run.held_n   = r_held;
                n_run.has_byte = 1'b1;
                n_held         = '0;
                n_ls           = is_cr;
            end
        end else begin
            n_run.has_byte = 1'b1;
            n_ls           = is_cr;
        end

        if (i_data.end_of_message) begin
            // only one of the two terms can be nonzero
            n_run.held_n = n_run.held_n + n_held;
            n_ls         = 1'b1;
            n_drop       = 1'b0;
            n_held       = '0;
        end

        n_run.vld = n_run.has_byte || (n_run.held_n != '0) || n_run.eom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls       <= 1'b1;
            r_drop     <= 1'b0;
            r_held     <= '0;
            r_pend.vld <= 1'b0;
        end else begin
            if (accept) begin
                r_ls   <= n_ls;
                r_drop <= n_drop;
                r_held <= n_held;
            end
            if (accept && n_run.vld) begin
                r_pend <= n_run;
            end else if (i_take) begin
                r_pend.vld <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < clks_pkg::CNT_W'(clks_pkg::PAT_LEN))
        else $error("held count out of range");

    a_drop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (!r_ls && r_held == '0))
        else $error("dropping line while at line start or holding");

    a_empty_run_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend.vld && !r_pend.has_byte && r_pend.held_n == '0) |-> r_pend.eom)
        else $error("empty run pending without end of message");
`endif

endmodule

/* rtl/clks_emit.sv */
// ----------------------------------------------------------------------------
// clks_emit
// Result sequencer. Loads one run descriptor and sends its result words
// one per cycle unless stalled: held pattern bytes, passed byte or end marker.
// ----------------------------------------------------------------------------
module clks_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clks_pkg::t_run      i_run,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_stall,
    output clks_pkg::t_out_word o_data
);

    clks_pkg::t_run               r_run;
    logic                         r_busy;
    logic [clks_pkg::CNT_W-1:0]   r_idx;

    logic [clks_pkg::CNT_W-1:0]   cnt;
    logic [clks_pkg::CNT_W-1:0]   last_idx;
    logic                         last;
    logic                         out_acc;

    assign cnt      = r_run.held_n + clks_pkg::CNT_W'(r_run.has_byte);
    assign last_idx = (cnt == '0) ? '0 : cnt - 1'b1;
    assign last     = (r_idx == last_idx);

    assign o_valid  = r_busy;
    assign out_acc  = r_busy && !i_stall;
    assign o_take   = i_run.vld && (!r_busy || (out_acc && last));

    always_comb begin
        o_data.run_last    = last;
        o_data.message_end = r_run.eom && last;
        if (r_idx < r_run.held_n) begin
            o_data.out_byte   = clks_pkg::pat_byte(r_idx);
            o_data.byte_valid = 1'b1;
        end else if (r_run.has_byte) begin
            o_data.out_byte   = r_run.data;
            o_data.byte_valid = 1'b1;
        end else begin
            o_data.out_byte   = 8'h00;
            o_data.byte_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_take) begin
            r_run  <= i_run;
            r_idx  <= '0;
            r_busy <= 1'b1;
        end else if (out_acc) begin
            // advance within the run, or go idle after its last word
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= last_idx))
        else $error("result index past end of run");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.message_end) |-> o_data.run_last)
        else $error("message end not on last word of run");

    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.byte_valid) |-> o_data.message_end)
        else $error("empty word outside end of message");
`endif

endmodule

/* rtl/control_line_kludge_stripper.sv */
// ----------------------------------------------------------------------------
// control_line_kludge_stripper
// Removes lines that start with 0x01 "INTL " from a message body byte
// stream, up to but not including the next carriage return.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_data (t_in_word)
//  output   out        o_valid / i_stall  o_data (t_out_word)
//
// One input word is taken per cycle while o_stall is low. Each word yields
// zero to six result words, sent one per cycle while i_stall is low by the
// result sequencer; a flush of held pattern bytes sets the burst length.
// A word's results pass the pending register, then the sequencer's run
// register. One run waits in the pending register, so one more word that
// yields results is taken while a result is stalled, and words that yield
// none flow until it is full. Reset is synchronous, active low. Input stalls
// only while a run is pending and the sequencer has not finished its run.
// ----------------------------------------------------------------------------
module control_line_kludge_stripper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  clks_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output clks_pkg::t_out_word o_data
);

    clks_pkg::t_run run;
    logic           take;

    clks_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_take  (take),
        .o_run   (run)
    );

    clks_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .o_take  (take),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
